[rtl/bmhq_pkg.sv]
`default_nettype none

package bmhq_pkg;

  // Fixed field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned FillW  = 11;
  localparam int unsigned StatW  = 2;

  // Default heap capacity
  localparam int unsigned CapacityDef = 1024;

  // Operation codes on the action field
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One finished result from the sequencer
  typedef struct packed {
    logic signed [KeyW-1:0] popped;
    status_e                status;
    logic [FillW-1:0]       fill;
  } res_t;

endpackage

`default_nettype wire

[rtl/bmhq_ram.sv]
`default_nettype none

module bmhq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic      [Width-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[rtl/bmhq_seq.sv]
`default_nettype none

module bmhq_seq #(
  parameter int unsigned CAPACITY = bmhq_pkg::CapacityDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            action_i,
  input  wire logic signed [bmhq_pkg::KeyW-1:0] value_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output bmhq_pkg::res_t                       res_o,
  output logic                                 we_o,
  output logic [$clog2(CAPACITY)-1:0]          waddr_o,
  output logic [bmhq_pkg::KeyW-1:0]            wdata_o,
  output logic                                 re_a_o,
  output logic [$clog2(CAPACITY)-1:0]          raddr_a_o,
  input  wire logic [bmhq_pkg::KeyW-1:0]       rdata_a_i,
  output logic                                 re_b_o,
  output logic [$clog2(CAPACITY)-1:0]          raddr_b_o,
  input  wire logic [bmhq_pkg::KeyW-1:0]       rdata_b_i
);

  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_DN_LD  = 8'b0000_1000,
    S_DN_RD  = 8'b0001_0000,
    S_DN_SEL = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          pick_q, pick_d;
  logic                   act_q, act_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] top_q, top_d;
  logic signed [KeyW-1:0] pick_val_q, pick_val_d;
  logic                   right_ok_q, right_ok_d;
  status_e                status_q, status_d;

  logic                   accept;
  logic [AW-1:0]          parent;
  logic [LW-1:0]          left_w, right_w, count_w;
  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic                   cmp_gt;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Tree index arithmetic
  assign parent  = AW'((pos_q - AW'(1)) >> 1);
  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = left_w + LW'(1);
  assign count_w = LW'(count_q);

  // Shared signed comparator: cmp_a > cmp_b
  always_comb begin
    cmp_a = key_q;
    cmp_b = $signed(rdata_a_i);
    unique case (state_q)
      S_DN_SEL: begin
        cmp_a = $signed(rdata_b_i);
        cmp_b = $signed(rdata_a_i);
      end
      S_DN_CMP: begin
        cmp_a = pick_val_q;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = $signed(rdata_a_i);
      end
    endcase
  end
  assign cmp_gt = cmp_a > cmp_b;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    pick_d     = pick_q;
    act_d      = act_q;
    key_d      = key_q;
    top_d      = top_q;
    pick_val_d = pick_val_q;
    right_ok_d = right_ok_q;
    status_d   = status_q;
    we_o       = 1'b0;
    waddr_o    = pos_q;
    wdata_o    = key_q;
    re_a_o     = 1'b0;
    raddr_a_o  = '0;
    re_b_o     = 1'b0;
    raddr_b_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d    = action_i;
          key_d    = value_i;
          status_d = ST_OK;
          if (action_i == ACT_PUSH) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              pos_d   = AW'(count_q);
              count_d = count_q + CW'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              // Fetch root and last entry
              count_d   = count_q - CW'(1);
              re_a_o    = 1'b1;
              raddr_a_o = '0;
              re_b_o    = 1'b1;
              raddr_b_o = AW'(count_q - CW'(1));
              state_d   = S_DN_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          we_o    = 1'b1;
          state_d = S_DONE;
        end else begin
          re_a_o    = 1'b1;
          raddr_a_o = parent;
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we_o = 1'b1;
        if (cmp_gt) begin
          // Parent is smaller: move it down and climb
          wdata_o = rdata_a_i;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DN_LD: begin
        top_d   = $signed(rdata_a_i);
        key_d   = $signed(rdata_b_i);
        pos_d   = '0;
        state_d = S_DN_RD;
      end

      S_DN_RD: begin
        if (left_w >= count_w) begin
          we_o    = 1'b1;
          state_d = S_DONE;
        end else begin
          re_a_o     = 1'b1;
          raddr_a_o  = AW'(left_w);
          re_b_o     = 1'b1;
          raddr_b_o  = AW'(right_w);
          right_ok_d = right_w < count_w;
          state_d    = S_DN_SEL;
        end
      end

      S_DN_SEL: begin
        // Right child only when strictly larger
        if (right_ok_q && cmp_gt) begin
          pick_d     = AW'(right_w);
          pick_val_d = $signed(rdata_b_i);
        end else begin
          pick_d     = AW'(left_w);
          pick_val_d = $signed(rdata_a_i);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        we_o = 1'b1;
        if (cmp_gt) begin
          wdata_o = pick_val_q;
          pos_d   = pick_q;
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result of the finished transaction
  assign res_valid_o   = (state_q == S_DONE);
  assign res_o.popped  = (act_q == ACT_POP && status_q == ST_OK) ? top_q : '0;
  assign res_o.status  = status_q;
  assign res_o.fill    = FillW'(count_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    pick_q     <= pick_d;
    act_q      <= act_d;
    key_q      <= key_d;
    top_q      <= top_d;
    pick_val_q <= pick_val_d;
    right_ok_q <= right_ok_d;
    status_q   <= status_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("sequencer idle right after accepting a transaction");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o && count_q != '0 |-> CW'(waddr_o) < count_q)
    else $error("heap write outside stored entries");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result dropped or changed while waiting");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_OK |-> res_o.popped == '0 && !we_o)
    else $error("failed operation popped a key or wrote the store");
`endif

endmodule

`default_nettype wire

[rtl/binary_max_heap_queue.sv]
`default_nettype none

// Binary max-heap priority queue of signed 32-bit keys.
// Input channel (in_valid_i / in_ready_o): action_i = 0 pushes value_i,
// action_i = 1 pops the largest key (value_i ignored). The block takes one
// transaction at a time; in_ready_o is low while a sift is running.
// Output channel (out_valid_o / out_ready_i): one result per transaction:
// popped_value_o (popped key, zero on a push or a failed pop), status_o
// (0 ok, 1 pop on empty heap, 2 push on full heap) and fill_count_o (entries
// after the operation). A failed operation leaves the heap untouched.
// A push places the key at the next free leaf and climbs while it is larger
// than its parent; a pop moves the last entry to the root and sinks it while
// its larger child is larger. The sift speed is set by the single keys RAM
// (registered read) and the one shared comparator, used once per level on
// push and twice on pop.
// A result register decouples the output: the next transaction is accepted
// while a result waits; a stalled receiver holds the sequencer in its final
// state once a second result is ready. Reset empties the heap at once; the
// key store itself is not cleared.

module binary_max_heap_queue #(
  parameter int unsigned CAPACITY = bmhq_pkg::CapacityDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              action_i,
  input  wire logic signed [bmhq_pkg::KeyW-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [bmhq_pkg::KeyW-1:0]       popped_value_o,
  output logic [bmhq_pkg::StatW-1:0]             status_o,
  output logic [bmhq_pkg::FillW-1:0]             fill_count_o
);

  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic            res_valid, res_ready;
  res_t            res;
  logic            we, re_a, re_b;
  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  logic [KeyW-1:0] wdata, rdata_a, rdata_b;

  logic            out_valid_q;
  res_t            out_q;

  bmhq_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_a_o      (re_a),
    .raddr_a_o   (raddr_a),
    .rdata_a_i   (rdata_a),
    .re_b_o      (re_b),
    .raddr_b_o   (raddr_b),
    .rdata_b_i   (rdata_b)
  );

  bmhq_ram #(
    .Width(KeyW),
    .Depth(CAPACITY)
  ) u_keys (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Result register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_q.popped;
  assign status_o       = out_q.status;
  assign fill_count_o   = out_q.fill;

endmodule

`default_nettype wire
